@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the load cell reader RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define LCR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define LCR_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ hw/rtl/lcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lcr_pkg
// Types and constants shared by the load cell reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

   localparam int DATA_BITS  = 24;
   localparam int RAW_W      = 24;
   localparam int OFFSET_W   = 24;
   localparam int SCALE_W    = 16;
   localparam int WEIGHT_W   = 25;
   localparam int CNT_W      = $clog2(DATA_BITS + 2);
   localparam int DIV_CNT_W  = $clog2(WEIGHT_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic signed [OFFSET_W-1:0] ZERO_OFFSET_RESET = 24'sd532166;
   localparam logic [SCALE_W-1:0]         SCALE_RESET       = 16'd368;

   localparam logic [CSR_IDX_W-1:0] REG_ZERO_OFFSET   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_DIVISOR = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_READY  = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_REPORT = 2'd2
   } seq_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE = 2'd0,
      DIV_RUN  = 2'd1,
      DIV_DONE = 2'd2
   } div_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/lcr_div.sv @@
// ----------------------------------------------------------------------------
// lcr_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lcr_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [lcr_pkg::WEIGHT_W-1:0]  dividend,
   input  wire logic [lcr_pkg::SCALE_W-1:0]          divisor,
   output lcr_pkg::div_status_type                   status,
   output logic signed [lcr_pkg::WEIGHT_W-1:0]       quotient
);

   localparam int QW = lcr_pkg::WEIGHT_W;
   localparam int DW = lcr_pkg::SCALE_W;

   lcr_pkg::div_state_type state_ff, state_in;
   logic [lcr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic          neg_ff, neg_in;

   logic [DW:0]   partial;
   logic [DW:0]   trial;
   logic          ge;
   logic          last_step;

   assign partial   = {rem_ff, quo_ff[QW-1]};
   assign trial     = partial - {1'b0, div_ff};
   assign ge        = partial >= {1'b0, div_ff};
   assign last_step = cnt_ff == lcr_pkg::DIV_CNT_W'(QW - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcr_pkg::DIV_IDLE: if (start) state_in = lcr_pkg::DIV_RUN;
         lcr_pkg::DIV_RUN:  if (last_step) state_in = lcr_pkg::DIV_DONE;
         lcr_pkg::DIV_DONE: state_in = lcr_pkg::DIV_IDLE;
         default:           state_in = lcr_pkg::DIV_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      if (start && state_ff == lcr_pkg::DIV_IDLE) begin
         neg_in = dividend[QW-1];
         quo_in = dividend[QW-1] ? QW'(-dividend) : QW'(dividend);
         rem_in = '0;
         cnt_in = '0;
         // zero divisor acts as one
         div_in = (divisor == '0) ? DW'(1) : divisor;
      end else if (state_ff == lcr_pkg::DIV_RUN) begin
         rem_in = ge ? trial[DW-1:0] : partial[DW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcr_pkg::DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign status.busy = state_ff != lcr_pkg::DIV_IDLE;
   assign status.done = state_ff == lcr_pkg::DIV_DONE;
   assign quotient    = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   `LCR_ASSERT(a_start_runs, clock, reset, (start && state_ff == lcr_pkg::DIV_IDLE) |=> (state_ff == lcr_pkg::DIV_RUN), "divider did not start")
   `LCR_ASSERT(a_done_after_run, clock, reset, status.done |-> $past(state_ff == lcr_pkg::DIV_RUN), "done without a full run")

endmodule

`default_nettype wire

@@ hw/rtl/load_cell_adc_serial_reader.sv @@
// Latency: a tick's result item is presented the cycle after its input item is accepted.
// The tick that ends a conversion runs the 25-step divider; its reading is registered after the
// divider start, the 25 steps, the done state and the output load.
// Throughput: 1 item per cycle between conversions while the output is not stalled; the closing
// tick stalls the input until its reading has been loaded into the output register.
// Reset (synchronous, active high): idle phase, counters cleared, offset 532166, scale 368.
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader
// Bit-banged serial reader for a 24-bit load cell converter with weight calibration.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module load_cell_adc_serial_reader (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // tick items in
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_data_pin,
   // result items out
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_clock_drive,
   output logic                                        rsp_reading_valid,
   output logic signed [lcr_pkg::RAW_W-1:0]            rsp_raw_code,
   output logic signed [lcr_pkg::WEIGHT_W-1:0]         rsp_weight,
   // configuration writes
   input  wire logic                                   csr_we,
   input  wire logic [lcr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [lcr_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int NB = lcr_pkg::DATA_BITS;
   localparam int CW = lcr_pkg::CNT_W;

   // ---------------- configuration registers ----------------
   logic signed [lcr_pkg::OFFSET_W-1:0] zero_offset_ff;
   logic [lcr_pkg::SCALE_W-1:0]         scale_divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff   <= lcr_pkg::ZERO_OFFSET_RESET;
         scale_divisor_ff <= lcr_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lcr_pkg::REG_ZERO_OFFSET:
               zero_offset_ff <= $signed(csr_wdata[lcr_pkg::OFFSET_W-1:0]);
            lcr_pkg::REG_SCALE_DIVISOR:
               scale_divisor_ff <= csr_wdata[lcr_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer and handshake ----------------
   lcr_pkg::seq_state_type state_ff, state_in;
   lcr_pkg::div_status_type div_status;
   logic signed [lcr_pkg::WEIGHT_W-1:0] div_quotient;

   logic out_free;      // output register empty or being taken this edge
   logic req_accept;
   logic final_tick;    // accepted tick is the falling edge of the gain pulse
   logic div_start;
   logic load_final;

   assign out_free   = !rsp_valid || !rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcr_pkg::ST_READY:  if (req_accept && final_tick) state_in = lcr_pkg::ST_DIVIDE;
         lcr_pkg::ST_DIVIDE: if (div_status.done) state_in = lcr_pkg::ST_REPORT;
         lcr_pkg::ST_REPORT: if (out_free) state_in = lcr_pkg::ST_READY;
         default:            state_in = lcr_pkg::ST_READY;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      div_start  = 1'b0;
      load_final = 1'b0;
      case (state_ff)
         lcr_pkg::ST_READY: begin
            req_stall = !out_free;
            div_start = req_accept && final_tick;
         end
         lcr_pkg::ST_REPORT: load_final = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lcr_pkg::ST_READY;
      else       state_ff <= state_in;
   end

   // ---------------- serial clock / shift logic ----------------
   lcr_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      pulse_count_ff, pulse_count_in;
   logic [NB-1:0]      shift_bits_ff, shift_bits_in;
   logic               clk_level;
   logic [CW-1:0]      count_next;

   assign count_next = pulse_count_ff + 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      pulse_count_in = pulse_count_ff;
      shift_bits_in  = shift_bits_ff;
      clk_level      = 1'b0;
      final_tick     = 1'b0;
      case (phase_ff)
         lcr_pkg::PH_HIGH: begin
            // falling edge: sample the data pin for the first NB pulses
            if (pulse_count_ff < CW'(NB))
               shift_bits_in = {shift_bits_ff[NB-2:0], req_data_pin};
            pulse_count_in = count_next;
            if (count_next >= CW'(NB + 1)) begin
               final_tick     = 1'b1;
               phase_in       = lcr_pkg::PH_IDLE;
               pulse_count_in = '0;
            end else begin
               phase_in = lcr_pkg::PH_LOW;
            end
         end
         lcr_pkg::PH_LOW: begin
            clk_level = 1'b1;
            phase_in  = lcr_pkg::PH_HIGH;
         end
         default: begin
            // idle, also the unused code: start when data-out goes low
            phase_in = lcr_pkg::PH_IDLE;
            if (!req_data_pin) begin
               clk_level      = 1'b1;
               phase_in       = lcr_pkg::PH_HIGH;
               pulse_count_in = '0;
               shift_bits_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= lcr_pkg::PH_IDLE;
         pulse_count_ff <= '0;
         shift_bits_ff  <= '0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         pulse_count_ff <= pulse_count_in;
         shift_bits_ff  <= shift_bits_in;
      end
   end

   // ---------------- conversion result ----------------
   logic signed [lcr_pkg::RAW_W-1:0]    raw_value;
   logic signed [lcr_pkg::WEIGHT_W-1:0] offset_diff;
   logic signed [lcr_pkg::RAW_W-1:0]    raw_hold_ff;

   // take the code as signed from its top bit
   assign raw_value   = lcr_pkg::RAW_W'($signed(shift_bits_in));
   assign offset_diff = lcr_pkg::WEIGHT_W'(zero_offset_ff) - lcr_pkg::WEIGHT_W'(raw_value);

   always_ff @(posedge clock) begin
      if (div_start) raw_hold_ff <= raw_value;
   end

   lcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset_diff),
      .divisor  (scale_divisor_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ---------------- output register ----------------
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_clock_drive_ff, rsp_clock_drive_in;
   logic                                rsp_reading_valid_ff, rsp_reading_valid_in;
   logic signed [lcr_pkg::RAW_W-1:0]    rsp_raw_code_ff, rsp_raw_code_in;
   logic signed [lcr_pkg::WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic                                load_tick;

   assign load_tick = req_accept && !final_tick;

   always_comb begin
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_clock_drive_in   = rsp_clock_drive_ff;
      rsp_reading_valid_in = rsp_reading_valid_ff;
      rsp_raw_code_in      = rsp_raw_code_ff;
      rsp_weight_in        = rsp_weight_ff;
      if (load_tick) begin
         rsp_valid_in         = 1'b1;
         rsp_clock_drive_in   = clk_level;
         rsp_reading_valid_in = 1'b0;
         rsp_raw_code_in      = '0;
         rsp_weight_in        = '0;
      end else if (load_final) begin
         // gain pulse has fallen: clock low, reading reported
         rsp_valid_in         = 1'b1;
         rsp_clock_drive_in   = 1'b0;
         rsp_reading_valid_in = 1'b1;
         rsp_raw_code_in      = raw_hold_ff;
         rsp_weight_in        = div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_clock_drive_ff   <= rsp_clock_drive_in;
      rsp_reading_valid_ff <= rsp_reading_valid_in;
      rsp_raw_code_ff      <= rsp_raw_code_in;
      rsp_weight_ff        <= rsp_weight_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clock_drive   = rsp_clock_drive_ff;
   assign rsp_reading_valid = rsp_reading_valid_ff;
   assign rsp_raw_code      = rsp_raw_code_ff;
   assign rsp_weight        = rsp_weight_ff;

   `LCR_ASSERT(a_stall_while_busy, clock, reset, (state_ff != lcr_pkg::ST_READY) |-> req_stall, "item accepted during division")
   `LCR_ASSERT(a_done_in_divide, clock, reset, div_status.done |-> (state_ff == lcr_pkg::ST_DIVIDE), "divider result with no conversion pending")
   `LCR_NEVER(a_start_when_busy, clock, reset, div_start && div_status.busy, "divider restarted while busy")
   `LCR_ASSERT(a_final_reports, clock, reset, load_final |=> (rsp_valid && rsp_reading_valid), "reading not presented")

endmodule

`default_nettype wire
